// File: src/imuma_pkg.sv
package imuma_pkg;

  localparam int NUM_CH     = 9;
  localparam int SAMPLE_W   = 16;
  localparam int ITEM_W     = NUM_CH * SAMPLE_W;
  localparam int WINDOW_DEF = 100;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_GYRO_OFS_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GYRO_OFS_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GYRO_OFS_Z = 2'd2;

  // Channel positions inside one item.
  localparam int CH_GYRO_X = 3;
  localparam int CH_GYRO_Y = 4;
  localparam int CH_GYRO_Z = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] item_t;

endpackage

// File: src/imuma_window.sv
module imuma_window #(
  parameter int WINDOW = imuma_pkg::WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  imuma_pkg::item_t       wdata,
  output imuma_pkg::item_t       old_data
);

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);

  logic [imuma_pkg::ITEM_W-1:0] mem [WINDOW];
  logic [imuma_pkg::ITEM_W-1:0] rd_q;
  logic [PW-1:0]                pos;
  logic                         filled;
  logic                         rd_filled;

  // Read-first port: the entry being replaced comes out while the new item goes in.
  always_ff @(posedge clk) begin
    if (wr) begin
      rd_q     <= mem[pos];
      mem[pos] <= wdata;
    end
  end

  // Until the first lap is complete, an entry ahead of the write pointer has never
  // been written and stands for a zero sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      filled    <= 1'b0;
      rd_filled <= 1'b0;
    end else if (wr) begin
      rd_filled <= filled;
      if (pos == LAST_POS) begin
        pos    <= '0;
        filled <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  assign old_data = rd_filled ? imuma_pkg::item_t'(rd_q) : '0;

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= LAST_POS)
    else $error("window pointer beyond the window");
  a_fill_sticky: assert property (@(posedge clk) disable iff (rst) filled |=> filled)
    else $error("fill flag dropped without reset");
  a_fill_wrap: assert property (@(posedge clk) disable iff (rst)
    wr && pos == LAST_POS |=> filled)
    else $error("fill flag not set at the end of the first lap");

endmodule

// File: src/imuma_div.sv
module imuma_div #(
  parameter int WINDOW = imuma_pkg::WINDOW_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [$clog2(WINDOW)+16-1:0]     sum_in,
  output imuma_pkg::sample_t                      avg
);

  localparam int SUM_W   = $clog2(WINDOW) + 16;
  localparam int SH      = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 2;
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  logic                       neg_a;
  logic [SUM_W-1:0]           mag_a;
  logic                       neg_b;
  logic [SUM_W+RECIP_W-1:0]   prod_b;
  logic [imuma_pkg::SAMPLE_W-1:0] quot;

  // Magnitude times a rounded-up reciprocal gives the exact floor for every
  // magnitude the running sum can reach, so the quotient truncates toward zero.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_a  <= sum_in[SUM_W-1];
      mag_a  <= sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
      neg_b  <= neg_a;
      prod_b <= (SUM_W+RECIP_W)'(mag_a) * (SUM_W+RECIP_W)'(RECIP);
    end
  end

  assign quot = prod_b[SH +: imuma_pkg::SAMPLE_W];
  assign avg  = neg_b ? imuma_pkg::sample_t'(-quot) : imuma_pkg::sample_t'(quot);

endmodule

// File: src/imu_nine_axis_moving_average.sv
// Channel  | Direction | Handshake                     | Payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | nine 16-bit samples
// m_axis   | out       | m_axis_tvalid / m_axis_tready | nine 16-bit window averages
// cfg      | in        | cfg_we                        | gyro offset registers 0 to 2
//
// One item per cycle while the result register is not waiting; m_axis_tvalid follows the edge
// that accepts an item through the stage flags v1, v2, v3 and v4 in turn.
// The rate is set by the single read-first port of the window memory, which reads
// the outgoing sample and writes the incoming one in the same cycle.
// Reset is synchronous and clears the pipeline, sums, offsets and window pointer.
// The window memory is not cleared: a fill flag makes entries read as zero until
// the first lap has written them, so no clearing pass is needed.
// When the result register waits, the whole pipeline holds and tready falls.
module imu_nine_axis_moving_average #(
  parameter int WINDOW = imuma_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, mag_x, mag_y, mag_z
  input  logic [imuma_pkg::ITEM_W-1:0]         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // avg_accel_x .. z, avg_gyro_x .. z, avg_mag_x .. z
  output logic [imuma_pkg::ITEM_W-1:0]         m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [imuma_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [imuma_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SUM_W = $clog2(WINDOW) + 16;

  imuma_pkg::sample_t gyro_ofs_x, gyro_ofs_y, gyro_ofs_z;
  imuma_pkg::item_t   in_item, corr_item, val_s1, old_s1;
  imuma_pkg::item_t   avg_item;
  logic [imuma_pkg::NUM_CH-1:0][SUM_W-1:0] sums;
  logic [imuma_pkg::NUM_CH-1:0][SUM_W-1:0] sums_next;
  logic               accept, adv;
  logic               v1, v2, v3, v4;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign in_item       = imuma_pkg::item_t'(s_axis_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_ofs_x <= '0;
      gyro_ofs_y <= '0;
      gyro_ofs_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        imuma_pkg::REG_GYRO_OFS_X: gyro_ofs_x <= cfg_wdata;
        imuma_pkg::REG_GYRO_OFS_Y: gyro_ofs_y <= cfg_wdata;
        imuma_pkg::REG_GYRO_OFS_Z: gyro_ofs_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Bias removal wraps modulo 2^16.
  always_comb begin
    corr_item = in_item;
    corr_item[imuma_pkg::CH_GYRO_X] = in_item[imuma_pkg::CH_GYRO_X] - gyro_ofs_x;
    corr_item[imuma_pkg::CH_GYRO_Y] = in_item[imuma_pkg::CH_GYRO_Y] - gyro_ofs_y;
    corr_item[imuma_pkg::CH_GYRO_Z] = in_item[imuma_pkg::CH_GYRO_Z] - gyro_ofs_z;
  end

  imuma_window #(.WINDOW(WINDOW)) u_window (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept),
    .wdata    (corr_item),
    .old_data (old_s1)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      val_s1 <= corr_item;
    end
  end

  always_comb begin
    for (int c = 0; c < imuma_pkg::NUM_CH; c++) begin
      sums_next[c] = SUM_W'($signed(sums[c]) + SUM_W'($signed(val_s1[c]))
                     - SUM_W'($signed(old_s1[c])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
    end else if (adv) begin
      if (v1) begin
        sums <= sums_next;
      end
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  for (genvar c = 0; c < imuma_pkg::NUM_CH; c++) begin : g_lane
    imuma_div #(.WINDOW(WINDOW)) u_div (
      .clk    (clk),
      .en     (adv),
      .sum_in (sums[c]),
      .avg    (avg_item[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v4) begin
      m_axis_tdata <= avg_item;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the result register is empty");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted item missing from the first stage");
  a_sums_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sums))
    else $error("running sums changed during a stall");

endmodule
